// File: sv/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  // coefficient and root format
  localparam int COEF_W        = 32;
  localparam int TOL_W         = 16;
  localparam int FRAC_BITS_DEF = 16;

  // discriminant and square root widths
  localparam int DW = 66;
  localparam int SW = DW / 2;
  localparam int RW = SW + 3;

  // divider operand widths
  localparam int NUM_W    = 35;
  localparam int NUM_MAGW = NUM_W - 1;
  localparam int DEN_W    = 34;
  localparam int DEN_MAGW = DEN_W - 1;

  // saturation limits of a 32-bit signed root
  localparam logic [63:0] SAT_NEG_MAG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SAT_POS_MAG = 64'h0000_0000_7FFF_FFFF;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  // solution kind decided ahead of the square root
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LIN,
    KIND_ONE,
    KIND_TWO
  } kind_t;

endpackage
`default_nettype wire

// File: sv/quadratic_root_solver.sv
`default_nettype none
// Solves a*x^2+b*x+c=0 for signed Q16.16 coefficients (s_tdata) and returns
// the root count and both roots in ascending order (m_tdata). A fully
// pipelined design: one coefficient set per cycle while the output is not
// held. The depth comes from the one-bit-per-stage square root (33 stages)
// and the one-bit-per-stage rounding dividers. A held output stalls the
// whole pipeline.
// zero_tolerance is written on the cfg channel and must only change while
// the pipeline is empty.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // config: zero_tolerance
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data,
  // tdata: coef_a, coef_b, coef_c
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [95:0]      s_tdata,
  // tdata: root_count, root_low, root_high, range_overflow, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [71:0]      m_tdata
);

  localparam int NW    = NUM_MAGW + FRAC_BITS + 1;
  localparam int DVLAT = NW + 1;

  logic [TOL_W-1:0] tol;
  logic             en;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(1);
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // global advance
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: input word
  logic                     v1;
  logic signed [COEF_W-1:0] a1, b1, c1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= s_tdata[31:0];
      b1 <= s_tdata[63:32];
      c1 <= s_tdata[95:64];
    end
  end

  // stage 2: magnitudes, products, near-zero flags
  logic [COEF_W-1:0]        am, bm, cm;
  logic                     v2, nza2, nzb2, nzc2;
  logic [2*COEF_W-1:0]      b2sq, pac;
  logic signed [COEF_W-1:0] a2, b2, c2;
  always_comb begin
    am = a1[COEF_W-1] ? COEF_W'(-a1) : COEF_W'(a1);
    bm = b1[COEF_W-1] ? COEF_W'(-b1) : COEF_W'(b1);
    cm = c1[COEF_W-1] ? COEF_W'(-c1) : COEF_W'(c1);
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b2sq <= bm * bm;
      pac  <= am * cm;
      nza2 <= am <= COEF_W'(tol);
      nzb2 <= bm <= COEF_W'(tol);
      nzc2 <= cm <= COEF_W'(tol);
      a2   <= a1;
      b2   <= b1;
      c2   <= c1;
    end
  end

  // stage 3: exact discriminant
  logic [DW-1:0]            p4w, b2w, dsum, ddif;
  logic                     v3, nza3, nzb3, nzc3, dneg3;
  logic [DW-1:0]            d3;
  logic signed [COEF_W-1:0] a3, b3, c3;
  always_comb begin
    p4w  = {pac, 2'b00};
    b2w  = DW'(b2sq);
    dsum = b2w + p4w;
    ddif = b2w - p4w;
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if ((a2[COEF_W-1] ^ c2[COEF_W-1]) && (pac != '0)) begin
        d3    <= dsum;
        dneg3 <= 1'b0;
      end else if (p4w <= b2w) begin
        d3    <= ddif;
        dneg3 <= 1'b0;
      end else begin
        d3    <= '0;
        dneg3 <= 1'b1;
      end
      nza3 <= nza2;
      nzb3 <= nzb2;
      nzc3 <= nzc2;
      a3   <= a2;
      b3   <= b2;
      c3   <= c2;
    end
  end

  // stage 4: case selection
  kind_t                    kind_w, k4;
  logic                     v4, dz;
  logic [DW-1:0]            d4;
  logic signed [COEF_W-1:0] a4, b4, c4;
  always_comb begin
    dz = d3 <= (DW'(tol) << FRAC_BITS);
    if (nza3) begin
      if (nzb3) kind_w = nzc3 ? KIND_INF : KIND_NONE;
      else      kind_w = KIND_LIN;
    end else if (dneg3) begin
      kind_w = KIND_NONE;
    end else if (dz) begin
      kind_w = KIND_ONE;
    end else begin
      kind_w = KIND_TWO;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k4 <= kind_w;
      d4 <= d3;
      a4 <= a3;
      b4 <= b3;
      c4 <= c3;
    end
  end

  // square root with matching side line
  logic [SW-1:0]            sroot;
  logic                     vsq [SW];
  kind_t                    ksq [SW];
  logic signed [COEF_W-1:0] asq [SW];
  logic signed [COEF_W-1:0] bsq [SW];
  logic signed [COEF_W-1:0] csq [SW];

  qrs_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (d4),
    .root (sroot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SW; i++) vsq[i] <= 1'b0;
    end else if (en) begin
      vsq[0] <= v4;
      for (int i = 1; i < SW; i++) vsq[i] <= vsq[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ksq[0] <= k4;
      asq[0] <= a4;
      bsq[0] <= b4;
      csq[0] <= c4;
      for (int i = 1; i < SW; i++) begin
        ksq[i] <= ksq[i-1];
        asq[i] <= asq[i-1];
        bsq[i] <= bsq[i-1];
        csq[i] <= csq[i-1];
      end
    end
  end

  // stage 5: quotient operands
  logic signed [NUM_W-1:0] nb, sx, n1_w, n1, n2;
  logic signed [DEN_W-1:0] den_w, den5;
  logic                    v5;
  kind_t                   k5;
  always_comb begin
    nb = -NUM_W'(bsq[SW-1]);
    sx = {2'b00, sroot};
    case (ksq[SW-1])
      KIND_LIN: begin
        n1_w  = -NUM_W'(csq[SW-1]);
        den_w = DEN_W'(bsq[SW-1]);
      end
      KIND_ONE: begin
        n1_w  = nb;
        den_w = {asq[SW-1][COEF_W-1], asq[SW-1], 1'b0};
      end
      default: begin
        n1_w  = nb - sx;
        den_w = {asq[SW-1][COEF_W-1], asq[SW-1], 1'b0};
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= vsq[SW-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n1   <= n1_w;
      n2   <= nb + sx;
      den5 <= den_w;
      k5   <= ksq[SW-1];
    end
  end

  // two rounding dividers in lockstep
  logic [NW-1:0] q1, q2;
  logic          ng1, ng2;
  logic          vdv [DVLAT];
  kind_t         kdv [DVLAT];

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_low (
    .clk (clk),
    .en  (en),
    .num (n1),
    .den (den5),
    .quo (q1),
    .neg (ng1)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_high (
    .clk (clk),
    .en  (en),
    .num (n2),
    .den (den5),
    .quo (q2),
    .neg (ng2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DVLAT; i++) vdv[i] <= 1'b0;
    end else if (en) begin
      vdv[0] <= v5;
      for (int i = 1; i < DVLAT; i++) vdv[i] <= vdv[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kdv[0] <= k5;
      for (int i = 1; i < DVLAT; i++) kdv[i] <= kdv[i-1];
    end
  end

  // stage 6: sign and saturation
  logic [COEF_W-1:0] r1_w, r2_w, r1, r2;
  logic              o1_w, o2_w, v6, ovf6;
  kind_t             k6;
  always_comb begin
    if (ng1) begin
      o1_w = q1 > NW'(SAT_NEG_MAG);
      r1_w = o1_w ? COEF_W'(SAT_NEG_MAG) : COEF_W'(-q1[COEF_W-1:0]);
    end else begin
      o1_w = q1 > NW'(SAT_POS_MAG);
      r1_w = o1_w ? COEF_W'(SAT_POS_MAG) : q1[COEF_W-1:0];
    end
    if (ng2) begin
      o2_w = q2 > NW'(SAT_NEG_MAG);
      r2_w = o2_w ? COEF_W'(SAT_NEG_MAG) : COEF_W'(-q2[COEF_W-1:0]);
    end else begin
      o2_w = q2 > NW'(SAT_POS_MAG);
      r2_w = o2_w ? COEF_W'(SAT_POS_MAG) : q2[COEF_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= vdv[DVLAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= r1_w;
      r2 <= r2_w;
      k6 <= kdv[DVLAT-1];
      case (kdv[DVLAT-1])
        KIND_LIN, KIND_ONE: ovf6 <= o1_w;
        KIND_TWO:           ovf6 <= o1_w | o2_w;
        default:            ovf6 <= 1'b0;
      endcase
    end
  end

  // stage 7: snap to zero, sort, output register
  logic [COEF_W-1:0]        m1, m2;
  logic signed [COEF_W-1:0] s1, s2;
  logic [1:0]               cnt_w, cnt;
  logic [COEF_W-1:0]        lo_w, hi_w, lo, hi;
  logic                     ovf_w, ovf;
  always_comb begin
    m1 = r1[COEF_W-1] ? COEF_W'(-r1) : r1;
    m2 = r2[COEF_W-1] ? COEF_W'(-r2) : r2;
    s1 = (m1 <= COEF_W'(tol)) ? '0 : r1;
    s2 = (m2 <= COEF_W'(tol)) ? '0 : r2;
    case (k6)
      KIND_LIN, KIND_ONE: begin
        cnt_w = CNT_ONE;
        lo_w  = s1;
        hi_w  = s1;
        ovf_w = ovf6;
      end
      KIND_TWO: begin
        cnt_w = CNT_TWO;
        lo_w  = (s2 < s1) ? s2 : s1;
        hi_w  = (s2 < s1) ? s1 : s2;
        ovf_w = ovf6;
      end
      KIND_INF: begin
        cnt_w = CNT_INF;
        lo_w  = '0;
        hi_w  = '0;
        ovf_w = 1'b0;
      end
      default: begin
        cnt_w = CNT_NONE;
        lo_w  = '0;
        hi_w  = '0;
        ovf_w = 1'b0;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cnt <= cnt_w;
      lo  <= lo_w;
      hi  <= hi_w;
      ovf <= ovf_w;
    end
  end

  assign m_tdata = {5'b0, ovf, hi, lo, cnt};

  // no roots or infinitely many carry zero payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (cnt == CNT_NONE || cnt == CNT_INF) |-> lo == '0 && hi == '0 && !ovf)
    else $error("payload not cleared for count without roots");

  // two roots leave in ascending order
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt == CNT_TWO |-> $signed(lo) <= $signed(hi))
    else $error("roots out of order");

  // a single root is reported twice
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt == CNT_ONE |-> lo == hi)
    else $error("single root differs between fields");

  // a held output keeps the pipeline frozen
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
    else $error("output changed while stalled");

endmodule
`default_nettype wire

// File: sv/qrs_isqrt.sv
`default_nettype none
module qrs_isqrt import qrs_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rad,
  output logic [SW-1:0] root
);

  logic [RW-1:0] rem_q   [SW];
  logic [SW-1:0] root_q  [SW];
  logic [DW-1:0] rad_q   [SW];
  logic [RW-1:0] rem_src [SW];
  logic [SW-1:0] root_src[SW];
  logic [DW-1:0] rad_src [SW];
  logic [RW-1:0] rem_sh  [SW];
  logic [RW-1:0] trial   [SW];
  logic [RW-1:0] rem_next [SW];
  logic [SW-1:0] root_next[SW];
  logic [DW-1:0] rad_next [SW];

  // one result bit per stage, restoring method
  always_comb begin
    for (int i = 0; i < SW; i++) begin
      if (i == 0) begin
        rem_src[i]  = '0;
        root_src[i] = '0;
        rad_src[i]  = rad;
      end else begin
        rem_src[i]  = rem_q[i-1];
        root_src[i] = root_q[i-1];
        rad_src[i]  = rad_q[i-1];
      end
      rem_sh[i] = {rem_src[i][RW-3:0], rad_src[i][DW-1 -: 2]};
      trial[i]  = {1'b0, root_src[i], 2'b01};
      if (rem_sh[i] >= trial[i]) begin
        rem_next[i]  = rem_sh[i] - trial[i];
        root_next[i] = {root_src[i][SW-2:0], 1'b1};
      end else begin
        rem_next[i]  = rem_sh[i];
        root_next[i] = {root_src[i][SW-2:0], 1'b0};
      end
      rad_next[i] = {rad_src[i][DW-3:0], 2'b00};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SW; i++) begin
        rem_q[i]  <= rem_next[i];
        root_q[i] <= root_next[i];
        rad_q[i]  <= rad_next[i];
      end
    end
  end

  assign root = root_q[SW-1];

endmodule
`default_nettype wire

// File: sv/qrs_div.sv
`default_nettype none
module qrs_div import qrs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NW = NUM_MAGW + FRAC_BITS + 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic [NW-1:0]           quo,
  output logic                    neg
);

  logic [NUM_W-1:0]    num_mag_w;
  logic [DEN_W-1:0]    den_mag_w;
  logic [DEN_MAGW-1:0] dm_pre;

  logic [DEN_MAGW:0]   rem_q [NW+1];
  logic [NW-1:0]       nq_q  [NW+1];
  logic [DEN_MAGW-1:0] dm_q  [NW+1];
  logic                neg_q [NW+1];

  logic [DEN_MAGW:0]   rem_sh   [NW];
  logic                ge       [NW];
  logic [DEN_MAGW:0]   rem_next [NW];

  // magnitudes and the rounding offset of half the divisor
  always_comb begin
    num_mag_w = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_mag_w = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    dm_pre    = den_mag_w[DEN_MAGW-1:0];
  end

  // one quotient bit per stage
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      rem_sh[i] = {rem_q[i][DEN_MAGW-1:0], nq_q[i][NW-1]};
      ge[i]     = rem_sh[i] >= {1'b0, dm_q[i]};
      rem_next[i] = ge[i] ? rem_sh[i] - {1'b0, dm_q[i]} : rem_sh[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= '0;
      nq_q[0]  <= (NW'(num_mag_w[NUM_MAGW-1:0]) << FRAC_BITS) + NW'(dm_pre >> 1);
      dm_q[0]  <= dm_pre;
      neg_q[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      for (int i = 0; i < NW; i++) begin
        rem_q[i+1] <= rem_next[i];
        nq_q[i+1]  <= {nq_q[i][NW-2:0], ge[i]};
        dm_q[i+1]  <= dm_q[i];
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  assign quo = nq_q[NW];
  assign neg = neg_q[NW];

endmodule
`default_nettype wire
